FILE: design/rpac_pkg.sv
// Package for the read-pair alignment classifier: types, codes and widths.
`timescale 1ns / 1ps
package rpac_pkg;

   // Field and register widths
   localparam int unsigned QUAL_W   = 8;
   localparam int unsigned LEN_W    = 16;
   localparam int unsigned OPT_W    = 4;
   localparam int unsigned OPLEN_W  = 28;
   localparam int unsigned Q16_W    = 17;
   localparam int unsigned PROD_W   = Q16_W + LEN_W;
   localparam int unsigned EDIT_W   = 32;
   localparam int unsigned FRAC_W   = 16;
   localparam int unsigned PCLS_W   = 3;
   localparam int unsigned CSR_IDX_W = 2;

   // Register reset values (0.2 and 0.1 in Q1.16)
   localparam logic [Q16_W-1:0]  CLIP_TOL_RESET = Q16_W'(13107);
   localparam logic [Q16_W-1:0]  MM_RATE_RESET  = Q16_W'(6554);
   localparam logic [QUAL_W-1:0] MIN_QUAL_RESET = '0;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_CLIP_TOL = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MM_RATE  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_QUAL = 2'd2;

   // CIGAR op codes that count as edits
   localparam logic [OPT_W-1:0] OP_INS  = 4'd1;
   localparam logic [OPT_W-1:0] OP_DEL  = 4'd2;
   localparam logic [OPT_W-1:0] OP_SOFT = 4'd4;
   localparam logic [OPT_W-1:0] OP_MISM = 4'd8;

   // Per-mate class
   typedef enum logic [2:0] {
      CLS_NONE     = 3'd0,
      CLS_ANCHOR   = 3'd1,
      CLS_ORPHAN   = 3'd2,
      CLS_SOFT     = 3'd3,
      CLS_MULTIPLE = 3'd4
   } mate_class_type;

   // Pair type codes
   localparam logic [PCLS_W-1:0] PAIR_ORPHAN   = 3'd0;
   localparam logic [PCLS_W-1:0] PAIR_SOFT     = 3'd1;
   localparam logic [PCLS_W-1:0] PAIR_MULTIPLE = 3'd2;
   localparam logic [PCLS_W-1:0] PAIR_NORMAL   = 3'd3;
   localparam logic [PCLS_W-1:0] PAIR_OTHER    = 3'd4;

   // One op after the front stage, with its per-item compares done
   typedef struct packed {
      logic               mate_select;
      logic               mate_unmapped;
      logic               qual_ok;
      logic               len_nonzero;
      logic               is_edit;
      logic [OPLEN_W-1:0] op_length;
      logic               first_op;
      logic               last_op;
      logic               is_clip;
      logic [PROD_W-1:0]  rate_bound;
   } op_item_type;

   // Result out of the classifier core
   typedef struct packed {
      logic              emit;
      logic [PCLS_W-1:0] pair_class;
      logic              mates_swapped;
   } pair_result_type;

endpackage

FILE: design/rpac_front.sv
// Front stage: input register with clip-limit and mismatch-bound products.
`timescale 1ns / 1ps
module rpac_front
   import rpac_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               take,
   input  logic               drain,
   input  logic               mate_select,
   input  logic               mate_unmapped,
   input  logic [QUAL_W-1:0]  map_quality,
   input  logic [LEN_W-1:0]   read_length,
   input  logic [OPT_W-1:0]   op_type,
   input  logic [OPLEN_W-1:0] op_length,
   input  logic               first_op,
   input  logic               last_op,
   input  logic [Q16_W-1:0]   clip_tol,
   input  logic [Q16_W-1:0]   mm_rate,
   input  logic [QUAL_W-1:0]  min_qual,
   output logic               item_valid,
   output op_item_type        item
);

   logic [PROD_W-1:0] clip_prod;
   logic [Q16_W-1:0]  clip_limit;
   op_item_type       item_in;
   op_item_type       item_ff;
   logic              valid_in;
   logic              valid_ff;

   // Per-item compares; the config must be stable while items are in flight (not enforced)
   always_comb begin
      clip_prod = PROD_W'(clip_tol) * PROD_W'(read_length);
      clip_limit = clip_prod[PROD_W-1:FRAC_W];
      item_in.mate_select   = mate_select;
      item_in.mate_unmapped = mate_unmapped;
      item_in.qual_ok       = (map_quality >= min_qual);
      item_in.len_nonzero   = (read_length != '0);
      item_in.is_edit       = (op_type == OP_INS) || (op_type == OP_DEL) ||
                              (op_type == OP_SOFT) || (op_type == OP_MISM);
      item_in.op_length     = op_length;
      item_in.first_op      = first_op;
      item_in.last_op       = last_op;
      item_in.is_clip       = (op_type == OP_SOFT) &&
                              (op_length >= OPLEN_W'(clip_limit));
      item_in.rate_bound    = PROD_W'(mm_rate) * PROD_W'(read_length);
   end

   // Occupancy
   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (drain) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= item_in;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

FILE: design/rpac_core.sv
// Classifier core: per-mate edit sum, head clip, mate class and pair type.
`timescale 1ns / 1ps
module rpac_core
   import rpac_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            fire,
   input  logic            mm_rate_on,
   input  op_item_type     item,
   output pair_result_type result
);

   logic [EDIT_W-1:0]   edit_sum_ff;
   logic [EDIT_W-1:0]   edit_sum_in;
   logic                head_clip_ff;
   logic                head_clip_in;
   mate_class_type      first_cls_ff;
   mate_class_type      first_cls_in;
   logic [EDIT_W-1:0]   edit_base;
   logic [EDIT_W:0]     edit_wide;
   logic [PROD_W+FRAC_W-1:0] edit_scaled;
   mate_class_type      cls;
   mate_class_type      partner;
   logic                swapped;
   logic [PCLS_W-1:0]   pair_code;

   // Edit sum and head clip, restarted on the first op of a mate
   always_comb begin
      edit_base    = item.first_op ? '0 : edit_sum_ff;
      head_clip_in = item.first_op ? item.is_clip : head_clip_ff;
      edit_wide    = {1'b0, edit_base} +
                     (item.is_edit ? (EDIT_W+1)'(item.op_length) : '0);
      edit_sum_in  = edit_wide[EDIT_W] ? '1 : edit_wide[EDIT_W-1:0];
      edit_scaled  = {(PROD_W+FRAC_W-EDIT_W)'(0), edit_sum_in} << FRAC_W;
   end

   // Mate class on its last op
   always_comb begin
      if (item.mate_unmapped) begin
         cls = CLS_ORPHAN;
      end else if (head_clip_in && item.is_clip) begin
         cls = CLS_NONE;
      end else if (head_clip_in || item.is_clip) begin
         cls = CLS_SOFT;
      end else if (item.qual_ok) begin
         cls = CLS_ANCHOR;
      end else if (mm_rate_on && item.len_nonzero &&
                   (edit_scaled <= (PROD_W+FRAC_W)'(item.rate_bound))) begin
         cls = CLS_MULTIPLE;
      end else begin
         cls = CLS_NONE;
      end
   end

   // Pair type: the anchor goes first, swapping if mate 1 holds it
   always_comb begin
      swapped = (first_cls_ff != CLS_ANCHOR) && (cls == CLS_ANCHOR);
      partner = swapped ? first_cls_ff : cls;
      pair_code = PAIR_OTHER;
      if (swapped || (first_cls_ff == CLS_ANCHOR)) begin
         case (partner)
            CLS_ORPHAN:   pair_code = PAIR_ORPHAN;
            CLS_SOFT:     pair_code = PAIR_SOFT;
            CLS_MULTIPLE: pair_code = PAIR_MULTIPLE;
            CLS_ANCHOR:   pair_code = PAIR_NORMAL;
            default:      pair_code = PAIR_OTHER;
         endcase
      end
      result.emit          = item.last_op && item.mate_select;
      result.pair_class    = pair_code;
      result.mates_swapped = swapped;
   end

   // Stored mate 0 class, cleared once a pair goes out
   always_comb begin
      first_cls_in = first_cls_ff;
      if (item.last_op) begin
         first_cls_in = item.mate_select ? CLS_NONE : cls;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         edit_sum_ff  <= '0;
         head_clip_ff <= 1'b0;
         first_cls_ff <= CLS_NONE;
      end else if (fire) begin
         edit_sum_ff  <= edit_sum_in;
         head_clip_ff <= head_clip_in;
         first_cls_ff <= first_cls_in;
      end
   end

endmodule

FILE: design/read_pair_alignment_classifier.sv
// Top level of the read-pair alignment classifier.
//
// Usage: CIGAR ops of mate 0 and then mate 1 arrive one item at a time on
// the req_ channel (valid/stall). One result item, the pair type and a
// swap flag, leaves on the rsp_ channel after the last op of mate 1;
// every other op produces no result.
// Path: an accepted op passes the front register, then the classifier
// core into the output register that drives rsp_valid.
// Throughput: one op per cycle unless a held result stalls a pair-ending
// op, set by the per-mate edit sum that the core reads and writes per op.
// While rsp_stall holds a result, ops that give no result keep flowing;
// the next pair-ending op waits in the front register and req_stall rises.
// Reset (synchronous, active high) clears the edit sum, head-clip flag,
// stored mate 0 class and all valid flags, and loads the register
// defaults (clip tolerance 0.2, mismatch rate 0.1, min quality 0). The user
// must write registers through csr_ only while the block is idle (not enforced).
`timescale 1ns / 1ps
module read_pair_alignment_classifier
   import rpac_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_mate_select,
   input  logic                 req_mate_unmapped,
   input  logic [QUAL_W-1:0]    req_map_quality,
   input  logic [LEN_W-1:0]     req_read_length,
   input  logic [OPT_W-1:0]     req_op_type,
   input  logic [OPLEN_W-1:0]   req_op_length,
   input  logic                 req_first_op,
   input  logic                 req_last_op,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [PCLS_W-1:0]    rsp_pair_class,
   output logic                 rsp_mates_swapped,
   input  logic                 csr_write_enable,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [Q16_W-1:0]     csr_write_data
);

   logic [Q16_W-1:0]  clip_tol_ff;
   logic [Q16_W-1:0]  mm_rate_ff;
   logic [QUAL_W-1:0] min_qual_ff;
   logic              item_valid;
   op_item_type       item;
   pair_result_type   result;
   logic              out_free;
   logic              advance;
   logic              take;
   logic              out_load;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic [PCLS_W-1:0] rsp_class_ff;
   logic              rsp_swap_ff;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         clip_tol_ff <= CLIP_TOL_RESET;
         mm_rate_ff  <= MM_RATE_RESET;
         min_qual_ff <= MIN_QUAL_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_CLIP_TOL: clip_tol_ff <= csr_write_data;
            CSR_MM_RATE:  mm_rate_ff  <= csr_write_data;
            CSR_MIN_QUAL: min_qual_ff <= csr_write_data[QUAL_W-1:0];
            default:      ;
         endcase
      end
   end

   // Flow control: only pair-ending items need the output register
   always_comb begin
      out_free  = !rsp_valid_ff || !rsp_stall;
      advance   = item_valid && (!result.emit || out_free);
      req_stall = item_valid && !advance;
      take      = req_valid && !req_stall;
      out_load  = advance && result.emit;
   end

   rpac_front u_front (
      .clock         (clock),
      .reset         (reset),
      .take          (take),
      .drain         (advance),
      .mate_select   (req_mate_select),
      .mate_unmapped (req_mate_unmapped),
      .map_quality   (req_map_quality),
      .read_length   (req_read_length),
      .op_type       (req_op_type),
      .op_length     (req_op_length),
      .first_op      (req_first_op),
      .last_op       (req_last_op),
      .clip_tol      (clip_tol_ff),
      .mm_rate       (mm_rate_ff),
      .min_qual      (min_qual_ff),
      .item_valid    (item_valid),
      .item          (item)
   );

   rpac_core u_core (
      .clock      (clock),
      .reset      (reset),
      .fire       (advance),
      .mm_rate_on (mm_rate_ff != '0),
      .item       (item),
      .result     (result)
   );

   // Output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_class_ff <= result.pair_class;
         rsp_swap_ff  <= result.mates_swapped;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_pair_class    = rsp_class_ff;
   assign rsp_mates_swapped = rsp_swap_ff;

   // Checks
   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> item_valid)
      else $error("req_stall with an empty front register");

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      out_load |=> rsp_valid)
      else $error("loaded result not presented");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !out_load)
      else $error("held result overwritten");

   a_swap_not_normal: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_mates_swapped) |-> (rsp_pair_class != PAIR_NORMAL))
      else $error("swapped pair reported as normal");

endmodule
